[rtl/heq_pkg.sv]
// ----------------------------------------------------------------------------
// heq_pkg
// Shared types and constants of the histogram equalizer.
// ----------------------------------------------------------------------------
package heq_pkg;

  // Number of gray levels and the top level
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned LEVEL_BITS = 8;
  localparam logic [7:0]  TOP_LEVEL  = 8'd255;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;

  // Item kinds as carried on in_tuser
  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_MAP   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Classified item as queued for the back end
  typedef struct packed {
    kind_t      kind;
    logic [7:0] gray;
    logic [7:0] alpha;
  } item_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

[rtl/heq_ram.sv]
// ----------------------------------------------------------------------------
// heq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/heq_front.sv]
// ----------------------------------------------------------------------------
// heq_front
// Input side: takes pixel transfers, derives the gray level and queues the
// classified item for the back end.
// ----------------------------------------------------------------------------
module heq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [31:0]    in_tdata,   // red, green, blue, alpha (low to high)
  input  logic [1:0]     in_tuser,   // kind
  output heq_pkg::head_t head,
  input  logic           pop
);

  localparam int PW = $clog2(heq_pkg::QDEPTH);

  heq_pkg::item_t   q_mem [heq_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic [12:0]      wsum;
  heq_pkg::item_t   new_item;
  logic             push;

  // Gray level: (r*11 + g*16 + b*5) / 32
  assign wsum = {5'd0, in_tdata[7:0]} * 13'd11
              + {1'b0, in_tdata[15:8], 4'd0}
              + {5'd0, in_tdata[23:16]} * 13'd5;

  assign new_item.kind  = heq_pkg::kind_t'(in_tuser);
  assign new_item.gray  = wsum[12:5];
  assign new_item.alpha = in_tdata[31:24];

  assign in_tready = (cnt_r != (PW+1)'(heq_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

[rtl/heq_back.sv]
// ----------------------------------------------------------------------------
// heq_back
// Execution side: histogram update, table build with a shared serial
// divider, table lookup, clearing sweeps and the output register.
// ----------------------------------------------------------------------------
module heq_back #(
  parameter int COUNT_BITS = 22
) (
  input  logic           clk,
  input  logic           rst_n,
  input  heq_pkg::head_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata
);

  localparam int CW = COUNT_BITS;
  localparam int DW = CW + 8;   // cumulative sum, shifted divisor
  localparam int NW = CW + 16;  // cumulative sum times 255
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CNT_WR, S_MAP_OUT, S_CLR,
    S_BLD_RD, S_BLD_ACC, S_BLD_DIV, S_BLD_WR
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [7:0]    gray_r, gray_nxt;
  logic [7:0]    alpha_r, alpha_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [DW-1:0] cdf_r, cdf_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [7:0]    q_r, q_nxt;
  logic [3:0]    stp_r, stp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_level_r, out_level_nxt;
  logic [7:0]    out_alpha_r, out_alpha_nxt;

  logic          hist_we;
  logic [7:0]    hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata, hist_rdata;
  logic          tbl_we;
  logic [7:0]    tbl_waddr, tbl_wdata, tbl_rdata;

  logic [DW-1:0] cdf_sum;
  logic          ge;

  heq_ram #(.WIDTH(CW), .DEPTH(heq_pkg::LEVELS)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  heq_ram #(.WIDTH(heq_pkg::LEVEL_BITS), .DEPTH(heq_pkg::LEVELS)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(head.item.gray), .rdata(tbl_rdata)
  );

  assign hist_raddr = (state_r == S_IDLE) ? head.item.gray : idx_r;
  assign cdf_sum    = cdf_r + {8'd0, hist_rdata};
  assign ge         = (num_r >= {8'd0, dv_r});

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_alpha_r, out_level_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    gray_nxt      = gray_r;
    alpha_nxt     = alpha_r;
    total_nxt     = total_r;
    cdf_nxt       = cdf_r;
    num_nxt       = num_r;
    dv_nxt        = dv_r;
    q_nxt         = q_r;
    stp_nxt       = stp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_level_nxt = out_level_r;
    out_alpha_nxt = out_alpha_r;
    pop           = 1'b0;
    hist_we       = 1'b0;
    hist_waddr    = idx_r;
    hist_wdata    = '0;
    tbl_we        = 1'b0;
    tbl_waddr     = idx_r;
    tbl_wdata     = '0;

    case (state_r)
      // Clearing pass after reset: histogram and table
      S_INIT: begin
        hist_we   = 1'b1;
        tbl_we    = 1'b1;
        total_nxt = '0;
        idx_nxt   = idx_r + 8'd1;
        if (idx_r == heq_pkg::TOP_LEVEL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          gray_nxt  = head.item.gray;
          alpha_nxt = head.item.alpha;
          idx_nxt   = '0;
          cdf_nxt   = '0;
          case (head.item.kind)
            heq_pkg::KIND_COUNT: begin
              pop       = 1'b1;
              state_nxt = S_CNT_WR;
            end
            heq_pkg::KIND_BUILD: begin
              pop       = 1'b1;
              state_nxt = S_BLD_RD;
            end
            heq_pkg::KIND_MAP: begin
              if (!out_valid_r) begin
                pop       = 1'b1;
                state_nxt = S_MAP_OUT;
              end
            end
            default: begin
              pop       = 1'b1;
              state_nxt = S_CLR;
            end
          endcase
        end
      end
      // Saturating bin and total increment
      S_CNT_WR: begin
        hist_we    = 1'b1;
        hist_waddr = gray_r;
        hist_wdata = (hist_rdata == CNT_MAX) ? hist_rdata : hist_rdata + 1'b1;
        total_nxt  = (total_r == CNT_MAX) ? total_r : total_r + 1'b1;
        state_nxt  = S_IDLE;
      end
      S_MAP_OUT: begin
        out_valid_nxt = 1'b1;
        out_level_nxt = tbl_rdata;
        out_alpha_nxt = alpha_r;
        state_nxt     = S_IDLE;
      end
      S_CLR: begin
        hist_we   = 1'b1;
        total_nxt = '0;
        idx_nxt   = idx_r + 8'd1;
        if (idx_r == heq_pkg::TOP_LEVEL) begin
          state_nxt = S_IDLE;
        end
      end
      // Bin read issued at idx_r
      S_BLD_RD: begin
        state_nxt = S_BLD_ACC;
      end
      S_BLD_ACC: begin
        cdf_nxt = cdf_sum;
        num_nxt = {cdf_sum, 8'd0} - {8'd0, cdf_sum};
        dv_nxt  = {total_r, 8'd0};
        q_nxt   = '0;
        stp_nxt = 4'd8;
        state_nxt = (total_r == '0) ? S_BLD_WR : S_BLD_DIV;
      end
      // Restoring division, one quotient bit a cycle; first step tests saturation
      S_BLD_DIV: begin
        dv_nxt = dv_r >> 1;
        if (stp_r == 4'd8) begin
          stp_nxt = 4'd7;
          if (ge) begin
            q_nxt     = heq_pkg::TOP_LEVEL;
            state_nxt = S_BLD_WR;
          end
        end else begin
          if (ge) begin
            num_nxt            = num_r - {8'd0, dv_r};
            q_nxt[stp_r[2:0]]  = 1'b1;
          end
          stp_nxt = stp_r - 4'd1;
          if (stp_r == 4'd0) begin
            state_nxt = S_BLD_WR;
          end
        end
      end
      S_BLD_WR: begin
        tbl_we    = 1'b1;
        tbl_wdata = q_r;
        idx_nxt   = idx_r + 8'd1;
        state_nxt = (idx_r == heq_pkg::TOP_LEVEL) ? S_IDLE : S_BLD_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    gray_r      <= gray_nxt;
    alpha_r     <= alpha_nxt;
    cdf_r       <= cdf_nxt;
    num_r       <= num_nxt;
    dv_r        <= dv_nxt;
    q_r         <= q_nxt;
    stp_r       <= stp_nxt;
    out_level_r <= out_level_nxt;
    out_alpha_r <= out_alpha_nxt;
  end

`ifndef SYNTHESIS
  a_reset_init: assert property (@(posedge clk) !rst_n |=> state_r == S_INIT)
    else $error("back end not in clearing pass after reset");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE && head.valid))
    else $error("queue popped outside idle");
  a_map_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.item.kind == heq_pkg::KIND_MAP) |=> !out_valid_r)
    else $error("map accepted while output register busy");
  a_map_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAP_OUT |=> out_valid_r)
    else $error("map item produced no result");
`endif

endmodule

[rtl/histogram_equalizer.sv]
// ----------------------------------------------------------------------------
// histogram_equalizer
// Gray-level histogram equalization of 8-bit pixels over stream channels.
// ----------------------------------------------------------------------------
// Each input transfer carries a pixel and a kind on in_tuser: count, build,
// map or clear. Only map items produce an output transfer: the equalized
// level and the pixel's alpha. A four-entry queue decouples the input from
// the execution engine. After reset the engine clears the histogram and
// table memories before it executes items (the queue still fills). Count
// and map items are bound by the registered read of the histogram or table
// RAM. Clear sweeps the histogram one bin a cycle. Build walks 256 bins,
// each by RAM read, accumulate, up to 9 steps of the serial divider and
// table write; the divider steps are skipped when the pixel total is zero.
module histogram_equalizer #(
  parameter int COUNT_BITS = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha (low to high)
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // level, alpha_out (low to high)
);

  heq_pkg::head_t head;
  logic           pop;

  heq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .head(head), .pop(pop)
  );

  heq_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .head(head), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

[tb/histogram_equalizer_tb.sv]
// ----------------------------------------------------------------------------
// histogram_equalizer_tb
// Self-checking bench for the gray histogram equalizer: directed and random
// count/build/map/clear streams with random idling and backpressure, checked
// in order against a behavioral predictor of histogram, total and table.
// ----------------------------------------------------------------------------
module histogram_equalizer_tb;

  localparam int CNT_W = 22;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Predictor: equalizer state and queue of expected map results
  class heq_scoreboard;
    logic [CNT_W-1:0] hist [256];
    logic [CNT_W-1:0] total;
    logic [7:0]       lut [256];
    logic [15:0]      pending [$];
    int               errors;
    int               maps;
    int               builds;

    function new();
      foreach (hist[i]) hist[i] = '0;
      foreach (lut[i]) lut[i] = '0;
      total = '0;
      errors = 0;
      maps = 0;
      builds = 0;
    endfunction

    function logic [7:0] gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [15:0] s;
      s = r * 16'd11 + g * 16'd16 + b * 16'd5;
      return s[12:5];
    endfunction

    // Apply one accepted input transfer to the model state
    function void note_input(heq_pkg::kind_t k, logic [31:0] d);
      logic [7:0] gl;
      logic [63:0] cdf, v;
      gl = gray(d[7:0], d[15:8], d[23:16]);
      case (k)
        heq_pkg::KIND_COUNT: begin
          if (hist[gl] != CNT_MAX) hist[gl]++;
          if (total != CNT_MAX) total++;
        end
        heq_pkg::KIND_BUILD: begin
          builds++;
          cdf = 0;
          for (int i = 0; i < 256; i++) begin
            cdf += hist[i];
            v = 0;
            if (total != 0) begin
              v = cdf * 255 / total;
              if (v > 255) v = 255;
            end
            lut[i] = v[7:0];
          end
        end
        heq_pkg::KIND_MAP: pending.push_back({d[31:24], lut[gl]});
        default: begin
          foreach (hist[i]) hist[i] = '0;
          total = '0;
        end
      endcase
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_output(logic [15:0] d);
      logic [15:0] e;
      if (pending.size() == 0) begin
        $error("unexpected output transfer %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      maps++;
      if (d[7:0] !== e[7:0]) begin
        $error("level: expected %0d actual %0d", e[7:0], d[7:0]);
        errors++;
      end
      if (d[15:8] !== e[15:8]) begin
        $error("alpha_out: expected %0d actual %0d", e[15:8], d[15:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  heq_scoreboard sb = new();
  bit long_hold = 1'b0;

  histogram_equalizer #(.COUNT_BITS(CNT_W)) dut (.*);

  always #5 clk = ~clk;

  // Send one item and wait for its transfer; valid stays up for the next item
  task automatic send_item(heq_pkg::kind_t k, logic [31:0] d, int gap);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_input(k, d);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly counts and maps; builds and clears are rare
  function automatic heq_pkg::kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return heq_pkg::KIND_COUNT;
    if (r < 96) return heq_pkg::KIND_MAP;
    if (r < 98) return heq_pkg::KIND_BUILD;
    return heq_pkg::KIND_CLEAR;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (w != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  // Stimulus
  initial begin
    int gap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: map before build, empty build, extremes, clear keeps table
    send_item(heq_pkg::KIND_MAP, 32'hFFFF_FFFF, 0);
    send_item(heq_pkg::KIND_MAP, 32'h0000_0000, 0);
    send_item(heq_pkg::KIND_BUILD, 32'h0, 0);
    send_item(heq_pkg::KIND_MAP, 32'h80FF_FFFF, 0);
    send_item(heq_pkg::KIND_COUNT, 32'h00FF_FFFF, 0);
    send_item(heq_pkg::KIND_COUNT, 32'h0000_0000, 0);
    send_item(heq_pkg::KIND_COUNT, 32'h0000_00FF, 0);
    send_item(heq_pkg::KIND_COUNT, 32'h0000_FF00, 0);
    send_item(heq_pkg::KIND_COUNT, 32'h00FF_0000, 0);
    send_item(heq_pkg::KIND_BUILD, 32'hFFFF_FFFF, 0);
    send_item(heq_pkg::KIND_MAP, 32'h1100_0000, 0);
    send_item(heq_pkg::KIND_MAP, 32'h22FF_FFFF, 0);
    send_item(heq_pkg::KIND_MAP, 32'h3300_FF00, 0);
    send_item(heq_pkg::KIND_MAP, 32'h4400_00FF, 0);
    send_item(heq_pkg::KIND_CLEAR, 32'h0, 0);
    send_item(heq_pkg::KIND_MAP, 32'hAA00_FF00, 0);
    send_item(heq_pkg::KIND_BUILD, 32'h0, 0);
    send_item(heq_pkg::KIND_MAP, 32'h5500_FF00, 0);

    // Long receiver hold-off while back-to-back maps fill the block
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_item(heq_pkg::KIND_MAP, $urandom, 0);
    wait_drained();

    // Random traffic, build/clear rare; stretches without gaps
    for (int i = 0; i < 900; i++) begin
      if ((i / 100) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 12);
      send_item(pick_kind(), $urandom, gap);
      if (i == 450) wait_drained();
      if (i % 150 == 149) send_item(heq_pkg::KIND_BUILD, $urandom, gap);
    end
    send_item(heq_pkg::KIND_BUILD, $urandom, 0);
    for (int i = 0; i < 8; i++) send_item(heq_pkg::KIND_MAP, $urandom, 0);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("summary: %0d maps checked, %0d table builds, random gaps and stalls",
             sb.maps, sb.builds);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
